@@ src/rstp_pkg.sv @@
// ----------------------------------------------------------------------------
// rstp_pkg
// Shared types and constants of the record slot table placement core.
// ----------------------------------------------------------------------------
package rstp_pkg;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 32;
    localparam int STAMP_W = 32;
    localparam int IDX_W   = 6;

    localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_FIND  = 2'd0,
        OP_STORE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

@@ src/record_slot_table_placement_core.sv @@
// ----------------------------------------------------------------------------
// record_slot_table_placement_core
// Slot table with find, store (into the matching slot, else an empty one, else oldest-stamp replacement) and clear.
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carry op and lookup_key; a transfer happens
// when i_valid is high and o_stall is low. output channel: o_valid / i_stall
// carry hit, slot_index, stamp and evicted, one result per input item.
// the slots live in one synchronous memory with a registered read. find and
// store walk every slot, one read per cycle, then resolve in the done state,
// and a new item is taken only once the last one has left the done state.
// clear writes every slot entry to zero, one slot per cycle. unused op codes
// answer with an all-zero result. after reset the block sweeps every slot of
// the memory to empty the table and holds o_stall high meanwhile.
// the result sits in an output register; the next item is taken while it
// waits. while i_stall is high the result holds, and a finished item waits
// in its last cycle until the output register is free.
// ----------------------------------------------------------------------------
module record_slot_table_placement_core #(
    parameter int SLOTS    = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [rstp_pkg::OP_W-1:0]         i_op,
    input  logic [rstp_pkg::KEY_W-1:0]        i_lookup_key,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_hit,
    output logic [rstp_pkg::IDX_W-1:0]        o_slot_index,
    output logic [rstp_pkg::STAMP_W-1:0]      o_stamp,
    output logic                              o_evicted
);

    localparam int IW   = $clog2(SLOTS);
    localparam int KW   = (KEY_BITS < rstp_pkg::KEY_W) ? KEY_BITS : rstp_pkg::KEY_W;
    localparam int SW   = rstp_pkg::STAMP_W;
    localparam int EW   = 1 + KW + SW;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    logic [EW-1:0] mem [SLOTS];
    logic [EW-1:0] r_rd_data;

    rstp_pkg::t_state r_state, n_state;
    rstp_pkg::t_op    r_op, n_op;
    logic [KW-1:0]    r_key, n_key;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic             r_issue, n_issue;
    logic             r_pvld, n_pvld;
    logic [IW-1:0]    r_pidx, n_pidx;

    logic             r_found, n_found;
    logic [IW-1:0]    r_first_slot, n_first_slot;
    logic [SW-1:0]    r_first_stamp, n_first_stamp;
    logic             r_match, n_match;
    logic [IW-1:0]    r_match_slot, n_match_slot;
    logic             r_empty, n_empty;
    logic [IW-1:0]    r_vacant_slot, n_vacant_slot;
    logic [SW-1:0]    r_oldest, n_oldest;
    logic [IW-1:0]    r_aged_slot, n_aged_slot;
    logic [SW-1:0]    r_largest, n_largest;

    logic             r_ovld, n_ovld;
    logic             r_hit, n_hit;
    logic [rstp_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [SW-1:0]    r_stamp, n_stamp;
    logic             r_evicted, n_evicted;

    logic             e_valid;
    logic [KW-1:0]    e_key;
    logic [SW-1:0]    e_stamp;
    logic             w_en;
    logic [IW-1:0]    w_addr;
    logic [EW-1:0]    w_data;
    logic             rd_en;
    logic             accept;
    logic             out_free;
    logic [IW-1:0]    target;
    logic [SW-1:0]    new_stamp;

    assign e_valid  = r_rd_data[EW-1];
    assign e_key    = r_rd_data[SW +: KW];
    assign e_stamp  = r_rd_data[SW-1:0];
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovld || !i_stall;
    assign rd_en    = (r_state == rstp_pkg::S_SCAN) && r_issue;
    assign target   = r_match ? r_match_slot : (r_empty ? r_vacant_slot : r_aged_slot);
    assign new_stamp = r_largest + SW'(1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_cnt];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_key         = r_key;
        n_cnt         = r_cnt;
        n_issue       = r_issue;
        n_pvld        = rd_en;
        n_pidx        = r_cnt;
        n_found       = r_found;
        n_first_slot  = r_first_slot;
        n_first_stamp = r_first_stamp;
        n_match       = r_match;
        n_match_slot  = r_match_slot;
        n_empty       = r_empty;
        n_vacant_slot = r_vacant_slot;
        n_oldest      = r_oldest;
        n_aged_slot   = r_aged_slot;
        n_largest     = r_largest;
        n_ovld        = r_ovld && i_stall;
        n_hit         = r_hit;
        n_idx         = r_idx;
        n_stamp       = r_stamp;
        n_evicted     = r_evicted;
        w_en          = 1'b0;
        w_addr        = r_cnt;
        w_data        = '0;

        case (r_state)
            rstp_pkg::S_INIT, rstp_pkg::S_CLEAR: begin
                w_en  = 1'b1;
                n_cnt = r_cnt + IW'(1);
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = (r_state == rstp_pkg::S_INIT) ? rstp_pkg::S_IDLE
                                                              : rstp_pkg::S_DONE;
                end
            end
            rstp_pkg::S_IDLE: begin
                if (accept) begin
                    n_op          = rstp_pkg::t_op'(i_op);
                    n_key         = i_lookup_key[KW-1:0];
                    n_cnt         = '0;
                    n_issue       = 1'b1;
                    n_found       = 1'b0;
                    n_first_slot  = '0;
                    n_first_stamp = '0;
                    n_match       = 1'b0;
                    n_match_slot  = '0;
                    n_empty       = 1'b0;
                    n_vacant_slot = '0;
                    n_oldest      = rstp_pkg::STAMP_MAX;
                    n_aged_slot   = '0;
                    n_largest     = '0;
                    case (rstp_pkg::t_op'(i_op))
                        rstp_pkg::OP_FIND, rstp_pkg::OP_STORE: n_state = rstp_pkg::S_SCAN;
                        rstp_pkg::OP_CLEAR: n_state = rstp_pkg::S_CLEAR;
                        default: n_state = rstp_pkg::S_DONE;
                    endcase
                end
            end
            rstp_pkg::S_SCAN: begin
                if (r_issue) begin
                    n_cnt = r_cnt + IW'(1);
                    if (r_cnt == LAST) begin
                        n_issue = 1'b0;
                        n_cnt   = '0;
                    end
                end
                if (r_pvld) begin
                    if (e_valid) begin
                        if (e_stamp > r_largest) begin
                            n_largest = e_stamp;
                        end
                        if (e_stamp < r_oldest) begin
                            n_oldest    = e_stamp;
                            n_aged_slot = r_pidx;
                        end
                        if (e_key == r_key) begin
                            n_match      = 1'b1;
                            n_match_slot = r_pidx;
                            if (!r_found) begin
                                n_found       = 1'b1;
                                n_first_slot  = r_pidx;
                                n_first_stamp = e_stamp;
                            end
                        end
                    end else if (!r_empty) begin
                        n_empty       = 1'b1;
                        n_vacant_slot = r_pidx;
                    end
                    if (r_pidx == LAST) begin
                        n_state = rstp_pkg::S_DONE;
                    end
                end
            end
            rstp_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovld    = 1'b1;
                    n_hit     = 1'b0;
                    n_idx     = '0;
                    n_stamp   = '0;
                    n_evicted = 1'b0;
                    n_state   = rstp_pkg::S_IDLE;
                    case (r_op)
                        rstp_pkg::OP_FIND: begin
                            n_hit   = r_found;
                            n_idx   = rstp_pkg::IDX_W'(16'(r_first_slot));
                            n_stamp = r_first_stamp;
                        end
                        rstp_pkg::OP_STORE: begin
                            w_en      = 1'b1;
                            w_addr    = target;
                            w_data    = {1'b1, r_key, new_stamp};
                            n_hit     = r_match;
                            n_idx     = rstp_pkg::IDX_W'(16'(target));
                            n_stamp   = new_stamp;
                            n_evicted = !r_match && !r_empty;
                        end
                        default: begin
                            n_hit = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = rstp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rstp_pkg::S_INIT;
            r_cnt   <= '0;
            r_issue <= 1'b0;
            r_pvld  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_issue <= n_issue;
            r_pvld  <= n_pvld;
            r_ovld  <= n_ovld;
        end
        r_op          <= n_op;
        r_key         <= n_key;
        r_pidx        <= n_pidx;
        r_found       <= n_found;
        r_first_slot  <= n_first_slot;
        r_first_stamp <= n_first_stamp;
        r_match       <= n_match;
        r_match_slot  <= n_match_slot;
        r_empty       <= n_empty;
        r_vacant_slot <= n_vacant_slot;
        r_oldest      <= n_oldest;
        r_aged_slot   <= n_aged_slot;
        r_largest     <= n_largest;
        r_hit         <= n_hit;
        r_idx         <= n_idx;
        r_stamp       <= n_stamp;
        r_evicted     <= n_evicted;
    end

    assign o_stall      = (r_state != rstp_pkg::S_IDLE);
    assign o_valid      = r_ovld;
    assign o_hit        = r_hit;
    assign o_slot_index = r_idx;
    assign o_stamp      = r_stamp;
    assign o_evicted    = r_evicted;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != rstp_pkg::S_IDLE))
        else $error("accepted transfer left the core idle");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rstp_pkg::S_DONE) && out_free) |=> o_valid)
        else $error("finished item did not reach the output register");

    a_hit_not_evicted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted))
        else $error("result marks both hit and eviction");

    a_read_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvld |-> (r_state == rstp_pkg::S_SCAN))
        else $error("read data returned outside the scan");

    a_no_write_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rstp_pkg::S_SCAN) |-> !w_en)
        else $error("memory written during the scan");

endmodule
